// ----- src/lhc_pkg.sv -----
// ----------------------------------------------------------------------------
// lhc_pkg
// Shared constants, types and helpers of the LRU handle cache.
// ----------------------------------------------------------------------------
package lhc_pkg;

  localparam int SLOTS    = 64;
  localparam int KEY_W    = 32;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int OCC_W    = $clog2(SLOTS + 1);
  localparam int CAP_W    = 7;
  localparam int CNT_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam int IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int OUT_BITS    = 1 + SLOT_W + 1 + KEY_W + OCC_W + 2 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  hit_total;
    logic [OCC_W-1:0]  occupancy;
    logic [KEY_W-1:0]  evicted_key;
    logic              evicted_valid;
    logic [SLOT_W-1:0] slot;
    logic              hit;
  } res_t;

  // one-hot (or zero) vector to slot index
  function automatic logic [SLOT_W-1:0] oh_to_idx(input logic [SLOTS-1:0] oh);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (oh[i]) idx = idx | SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- src/lhc_in_stage.sv -----
// ----------------------------------------------------------------------------
// lhc_in_stage
// Input register: holds one request until the core consumes it.
// ----------------------------------------------------------------------------
module lhc_in_stage
  import lhc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  input  logic take_i,
  output logic req_valid_o,
  output req_t req_o
);

  logic valid_q;
  req_t req_q;

  assign in_ready_o  = !valid_q || take_i;
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
  end

endmodule

// ----- src/lhc_core.sv -----
// ----------------------------------------------------------------------------
// lhc_core
// Tag store, recency ranks and counters; parallel lookup and update.
// ----------------------------------------------------------------------------
module lhc_core
  import lhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CAP_W-1:0] cap_i,
  input  logic             fire_i,
  input  req_t             req_i,
  output res_t             res_o
);

  logic [SLOTS-1:0]  valid_q;
  logic [KEY_W-1:0]  key_q  [SLOTS];
  logic [SLOT_W-1:0] rank_q [SLOTS];
  logic [OCC_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]  miss_cnt_q, miss_cnt_d;

  logic [OCC_W-1:0]  eff_cap;
  logic [SLOTS-1:0]  match, victim, free_oh, slot_oh;
  logic              hit, need_evict, access;
  logic [SLOT_W-1:0] hit_rank, lru_rank;
  logic [KEY_W-1:0]  ev_key;

  always_comb begin
    if (cap_i == '0) begin
      eff_cap = OCC_W'(1);
    end else if (32'(cap_i) > 32'(SLOTS)) begin
      eff_cap = OCC_W'(SLOTS);
    end else begin
      eff_cap = OCC_W'(cap_i);
    end
  end

  // ranks of valid entries are always a permutation of 0..count-1,
  // so the least recent entry is the one ranked count-1
  assign lru_rank = SLOT_W'(count_q - OCC_W'(1));

  always_comb begin
    hit_rank = '0;
    ev_key   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == req_i.key);
      victim[i] = valid_q[i] && (rank_q[i] == lru_rank);
      if (match[i]) hit_rank = hit_rank | rank_q[i];
    end
    hit        = |match;
    need_evict = (count_q >= eff_cap) && !hit;
    free_oh    = ~valid_q & (valid_q + SLOTS'(1));
    for (int i = 0; i < SLOTS; i++) begin
      if (victim[i] && need_evict) ev_key = ev_key | key_q[i];
    end
    if (hit) begin
      slot_oh = match;
    end else if (need_evict) begin
      slot_oh = victim;
    end else begin
      slot_oh = free_oh;
    end
  end

  assign access = fire_i && (req_i.op == OP_ACCESS);

  always_comb begin
    count_d    = count_q;
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (req_i.op == OP_FLUSH) begin
      count_d = '0;
    end else if (hit) begin
      if (hit_cnt_q != CNT_MAX) hit_cnt_d = hit_cnt_q + CNT_W'(1);
    end else begin
      if (miss_cnt_q != CNT_MAX) miss_cnt_d = miss_cnt_q + CNT_W'(1);
      if (!need_evict) count_d = count_q + OCC_W'(1);
    end
  end

  always_comb begin
    res_o = '0;
    res_o.occupancy  = count_d;
    res_o.hit_total  = hit_cnt_d;
    res_o.miss_total = miss_cnt_d;
    if (req_i.op == OP_ACCESS) begin
      res_o.hit           = hit;
      res_o.slot          = oh_to_idx(slot_oh);
      res_o.evicted_valid = need_evict;
      res_o.evicted_key   = ev_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      count_q    <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (fire_i) begin
      count_q    <= count_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      if (req_i.op == OP_FLUSH) begin
        valid_q <= '0;
      end else begin
        valid_q <= valid_q | slot_oh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (access) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_oh[i]) begin
          rank_q[i] <= '0;
          if (!hit) key_q[i] <= req_i.key;
        end else if (valid_q[i] && (!hit || rank_q[i] < hit_rank)) begin
          rank_q[i] <= rank_q[i] + SLOT_W'(1);
        end
      end
    end
  end

endmodule

// ----- src/lru_handle_cache.sv -----
// ----------------------------------------------------------------------------
// lru_handle_cache
// Fully associative LRU cache of file handles keyed by a fixed-width key.
// ----------------------------------------------------------------------------
// Requests are taken and results stream at one per clock while m_axis_tready
// holds. A request waits in the input register, is looked up against all
// slots at once, and its result is registered in the output register. The
// rate is set by the tag compare and rank update across all slots, since
// every request depends on the recency order the previous one leaves. A
// flush clears every slot and keeps the hit and miss totals. The capacity
// register is written over the cfg channel; the user must write it only
// while the block is idle, which the block does not enforce; zero acts as
// one and values above the slot count act as the slot count.
module lru_handle_cache
  import lhc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CAP_W-1:0]       cfg_data_i,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key
  input  logic                   s_axis_tuser,   // operation
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit, slot, evicted_valid, evicted_key, occupancy, hit_total, miss_total
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [CAP_W-1:0] cap_q;
  req_t             in_req, req;
  logic             req_valid, fire;
  res_t             res, res_q;
  logic             m_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  assign in_req.op  = s_axis_tuser;
  assign in_req.key = s_axis_tdata[KEY_W-1:0];

  assign fire = req_valid && (!m_valid_q || m_axis_tready);

  lhc_in_stage u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (in_req),
    .take_i      (fire),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  lhc_core u_core (
    .clk_i,
    .rst_ni,
    .cap_i  (cap_q),
    .fire_i (fire),
    .req_i  (req),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(res_q);

endmodule

// ----- src/lhc_checker.sv -----
// ----------------------------------------------------------------------------
// lhc_checker
// Port-level checks of the LRU handle cache, bound to the top level.
// ----------------------------------------------------------------------------
module lhc_checker
  import lhc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  res_t             res;
  logic [CNT_W-1:0] last_hit_q, last_miss_q;
  logic [CNT_W-1:0] next_hit, next_miss;

  assign res = res_t'(m_axis_tdata[OUT_BITS-1:0]);

  // totals of the last result transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hit_q  <= '0;
      last_miss_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_hit_q  <= res.hit_total;
      last_miss_q <= res.miss_total;
    end
  end

  assign next_hit  = (last_hit_q == CNT_MAX) ? last_hit_q : last_hit_q + CNT_W'(1);
  assign next_miss = (last_miss_q == CNT_MAX) ? last_miss_q : last_miss_q + CNT_W'(1);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.hit |->
      res.hit_total == next_hit && res.miss_total == last_miss_q)
    else $error("hit did not advance hit total alone");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.hit && res.occupancy != '0 |->
      res.miss_total == next_miss && res.hit_total == last_hit_q)
    else $error("miss did not advance miss total alone");

  a_flush_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.occupancy == '0 |->
      !res.hit && !res.evicted_valid && res.hit_total == last_hit_q &&
      res.miss_total == last_miss_q)
    else $error("flush result inconsistent");

endmodule

bind lru_handle_cache lhc_checker u_lhc_checker (.*);

// ----- sim/lru_handle_cache_tb.sv -----
// ----------------------------------------------------------------------------
// lru_handle_cache_tb
// Self-checking bench for the LRU handle cache. A short table of directed
// requests and capacity writes comes first, then randomized phases at
// different capacities with keys drawn from a small pool so hits, misses and
// evictions all happen. Untyped results are checked by a local LRU model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lru_handle_cache_tb;
  import lhc_pkg::*;

  localparam int RES_BITS    = $bits(res_t);
  localparam int STALL_LIMIT = 4000;
  localparam int POOL_DEPTH  = 128;
  localparam int PHASE_ITEMS = 90;
  localparam int PHASES      = 12;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CAP_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // key
  logic                   s_axis_tuser;   // operation
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // hit, slot, evicted_valid, evicted_key, occupancy, hit_total, miss_total
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  lru_handle_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cache model state
  logic             line_valid [SLOTS];
  logic [KEY_W-1:0] line_key   [SLOTS];
  int unsigned      line_age   [SLOTS];  // 0 = most recent
  int unsigned      line_count;
  logic [CNT_W-1:0] hits_seen;
  logic [CNT_W-1:0] misses_seen;
  logic [CAP_W-1:0] cap_setting;

  res_t        pending_results [$];
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned stall_cycles;
  logic        calm;

  typedef struct {
    logic             do_cfg;
    logic [CAP_W-1:0] cap;
    logic             op;
    logic [KEY_W-1:0] key;
    logic             typed;
    res_t             want;
  } script_row_t;

  script_row_t script [$];

  function automatic int unsigned cap_limit();
    if (cap_setting == 0) return 1;
    if (cap_setting > SLOTS) return SLOTS;
    return 32'(cap_setting);
  endfunction

  function automatic res_t cache_access(input logic op, input logic [KEY_W-1:0] key);
    res_t        r;
    int          found;
    int          victim;
    int unsigned age;
    r = '0;
    if (op == OP_FLUSH) begin
      for (int i = 0; i < SLOTS; i++) line_valid[i] = 1'b0;
      line_count = 0;
    end else begin
      found = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
      end
      if (found >= 0) begin
        r.hit  = 1'b1;
        r.slot = SLOT_W'(found);
        if (hits_seen != CNT_MAX) hits_seen++;
        age = line_age[found];
        for (int i = 0; i < SLOTS; i++) begin
          if (line_valid[i] && line_age[i] < age) line_age[i]++;
        end
        line_age[found] = 0;
      end else begin
        if (misses_seen != CNT_MAX) misses_seen++;
        victim = -1;
        if (line_count >= cap_limit()) begin
          // oldest entry goes, lowest slot on a tie
          for (int i = 0; i < SLOTS; i++) begin
            if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim])) victim = i;
          end
          if (victim >= 0) begin
            r.evicted_valid = 1'b1;
            r.evicted_key   = line_key[victim];
            line_valid[victim] = 1'b0;
            line_count--;
          end
        end
        if (victim < 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (victim < 0 && !line_valid[i]) victim = i;
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (line_valid[i]) line_age[i]++;
        end
        line_valid[victim] = 1'b1;
        line_key[victim]   = key;
        line_age[victim]   = 0;
        line_count++;
        r.slot = SLOT_W'(victim);
      end
    end
    r.occupancy  = OCC_W'(line_count);
    r.hit_total  = hits_seen;
    r.miss_total = misses_seen;
    return r;
  endfunction

  function automatic res_t result_of(input logic hit, input int unsigned slot,
                                     input logic ev_valid, input logic [KEY_W-1:0] ev_key,
                                     input int unsigned occ, input int unsigned hits,
                                     input int unsigned misses);
    res_t r;
    r.hit           = hit;
    r.slot          = SLOT_W'(slot);
    r.evicted_valid = ev_valid;
    r.evicted_key   = ev_key;
    r.occupancy     = OCC_W'(occ);
    r.hit_total     = CNT_W'(hits);
    r.miss_total    = CNT_W'(misses);
    return r;
  endfunction

  task automatic add_row(input logic do_cfg, input logic [CAP_W-1:0] cap, input logic op,
                         input logic [KEY_W-1:0] key, input logic typed, input res_t want);
    script_row_t row;
    row.do_cfg = do_cfg;
    row.cap    = cap;
    row.op     = op;
    row.key    = key;
    row.typed  = typed;
    row.want   = want;
    script.push_back(row);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $time, results_seen, what);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [KEY_W-1:0] got,
                               input logic [KEY_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Called and returns just after a falling edge.
  task automatic issue_request(input logic op, input logic [KEY_W-1:0] key,
                               input logic typed, input res_t want);
    res_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_TDATA_W'(key);
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = cache_access(op, key);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Capacity changes only once every pending result has drained.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_setting = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Result stream backpressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      if (!calm) repeat ($urandom_range(0, 20)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[RES_BITS-1:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("hit", KEY_W'(got.hit), KEY_W'(want.hit));
        compare_field("slot", KEY_W'(got.slot), KEY_W'(want.slot));
        compare_field("evicted_valid", KEY_W'(got.evicted_valid), KEY_W'(want.evicted_valid));
        compare_field("evicted_key", got.evicted_key, want.evicted_key);
        compare_field("occupancy", KEY_W'(got.occupancy), KEY_W'(want.occupancy));
        compare_field("hit_total", got.hit_total, want.hit_total);
        compare_field("miss_total", got.miss_total, want.miss_total);
      end
      results_seen++;
    end
  end

  // Watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool [POOL_DEPTH];
    logic [CAP_W-1:0] phase_caps [PHASES];
    int unsigned      pool_n;
    logic [KEY_W-1:0] k;
    logic             op;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ACCESS;
    calm          = 1'b0;
    mismatch_count = 0;
    results_seen   = 0;
    stall_cycles   = 0;
    for (int i = 0; i < SLOTS; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_age[i]   = 0;
    end
    line_count  = 0;
    hits_seen   = '0;
    misses_seen = '0;
    cap_setting = CAP_RESET;

    // Directed table. Typed rows: after reset, flush, capacity one and zero.
    add_row(0, 0, OP_ACCESS, 32'h0000_0000, 1, result_of(0, 0, 0, 0, 1, 0, 1));
    add_row(0, 0, OP_ACCESS, 32'hFFFF_FFFF, 1, result_of(0, 1, 0, 0, 2, 0, 2));
    add_row(0, 0, OP_ACCESS, 32'h0000_0000, 1, result_of(1, 0, 0, 0, 2, 1, 2));
    add_row(0, 0, OP_ACCESS, 32'h8000_0000, 0, '0);
    add_row(0, 0, OP_ACCESS, 32'h0000_0001, 0, '0);
    add_row(0, 0, OP_FLUSH,  32'h0000_0000, 1, result_of(0, 0, 0, 0, 0, 1, 4));
    add_row(1, 1, OP_ACCESS, 32'h1234_5678, 1, result_of(0, 0, 0, 0, 1, 1, 5));
    add_row(0, 0, OP_ACCESS, 32'h1234_5678, 1, result_of(1, 0, 0, 0, 1, 2, 5));
    add_row(0, 0, OP_ACCESS, 32'hA5A5_A5A5, 1,
            result_of(0, 0, 1, 32'h1234_5678, 1, 2, 6));
    // zero capacity behaves as one
    add_row(1, 0, OP_ACCESS, 32'h5A5A_5A5A, 1,
            result_of(0, 0, 1, 32'hA5A5_A5A5, 1, 2, 7));
    add_row(1, 2, OP_ACCESS, 32'h0000_0001, 0, '0);
    add_row(0, 0, OP_ACCESS, 32'h0000_0002, 0, '0);
    add_row(0, 0, OP_ACCESS, 32'h0000_0001, 0, '0);
    add_row(0, 0, OP_ACCESS, 32'h0000_0003, 0, '0);
    add_row(1, 127, OP_ACCESS, 32'h0000_000A, 0, '0);
    add_row(0, 0, OP_ACCESS, 32'h0000_000B, 0, '0);
    add_row(0, 0, OP_ACCESS, 32'h0000_000C, 0, '0);
    // capacity dropped under occupancy without a flush
    add_row(1, 1, OP_ACCESS, 32'h0000_000D, 0, '0);
    add_row(0, 0, OP_ACCESS, 32'h0000_000E, 0, '0);
    add_row(0, 0, OP_ACCESS, 32'h0000_000C, 0, '0);
    add_row(0, 0, OP_FLUSH,  32'hFFFF_FFFF, 0, '0);
    add_row(1, 64, OP_ACCESS, 32'hDEAD_BEEF, 0, '0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      if (script[i].do_cfg) set_capacity(script[i].cap);
      issue_request(script[i].op, script[i].key, script[i].typed, script[i].want);
    end

    phase_caps = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd5, 7'd16, 7'd33,
                   7'd63, 7'd3, 7'd100, 7'd8};
    for (int p = 0; p < PHASES; p++) begin
      if (p >= PHASES - 2) calm = 1'b1;
      // each phase keeps old contents over the capacity change at even odds
      if ($urandom_range(0, 1) == 0) issue_request(OP_FLUSH, $urandom, 0, '0);
      set_capacity(phase_caps[p]);
      for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = $urandom;
      pool_n = cap_limit() + $urandom_range(1, cap_limit() / 2 + 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 39) == 0) ? OP_FLUSH : OP_ACCESS;
        if ($urandom_range(0, 15) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, pool_n - 1)];
        issue_request(op, k, 0, '0);
      end
    end

    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
